### rtl/core/i2cmrs_pkg.sv
// ----------------------------------------------------------------------------
// i2cmrs_pkg
// Shared codes and item types for the I2C register sequencer.
// ----------------------------------------------------------------------------
package i2cmrs_pkg;

	localparam logic [1:0] OP_START_WRITE = 2'd0;
	localparam logic [1:0] OP_START_READ  = 2'd1;
	localparam logic [1:0] OP_SHIFT_DONE  = 2'd2;
	localparam logic [1:0] OP_UNUSED      = 2'd3;

	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_STOP  = 2'd2;

	localparam logic [3:0] CNT_NONE = 4'd0;
	localparam logic [3:0] CNT_ACK  = 4'd1;
	localparam logic [3:0] CNT_BYTE = 4'd8;

	localparam logic [7:0] BYTE_RELEASED = 8'hFF;
	localparam logic [7:0] BYTE_ZERO     = 8'h00;
	localparam logic [7:0] READ_BIT      = 8'h01;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] reg_address;
		logic [7:0] write_data;
		logic [7:0] shifted_in;
	} cmd_t;

	typedef struct packed {
		logic [7:0] shift_value;
		logic [3:0] bit_count;
		logic       sda_drive;
		logic [1:0] line_action;
		logic       done_res;
		logic [7:0] read_data;
	} result_t;

endpackage

### rtl/core/i2cmrs_if.sv
// ----------------------------------------------------------------------------
// i2cmrs_if
// Valid/ready channels of the I2C register sequencer.
// ----------------------------------------------------------------------------
interface i2cmrs_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] reg_address;
	logic [7:0] write_data;
	logic [7:0] shifted_in;

	modport source (output valid, output operation, output reg_address,
		output write_data, output shifted_in, input ready);
	modport sink (input valid, input operation, input reg_address,
		input write_data, input shifted_in, output ready);
endinterface

interface i2cmrs_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] shift_value;
	logic [3:0] bit_count;
	logic       sda_drive;
	logic [1:0] line_action;
	logic       done_res;
	logic [7:0] read_data;

	modport source (output valid, output shift_value, output bit_count,
		output sda_drive, output line_action, output done_res,
		output read_data, input ready);
	modport sink (input valid, input shift_value, input bit_count,
		input sda_drive, input line_action, input done_res,
		input read_data, output ready);
endinterface

interface i2cmrs_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/i2cmrs_seq.sv
// ----------------------------------------------------------------------------
// i2cmrs_seq
// Transaction state and per-item decision logic of the sequencer.
// ----------------------------------------------------------------------------
module i2cmrs_seq import i2cmrs_pkg::*; #(
	parameter int WRITE_BYTES = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  cmd_t       cmd,
	input  logic       cfg_we,
	input  logic [7:0] cfg_data,
	output result_t    result
);

	localparam logic [1:0] LastCnt = 2'(WRITE_BYTES);
	localparam logic [1:0] TxCnt   = 2'(WRITE_BYTES - 2);

	typedef enum logic [3:0] {
		PH_IDLE           = 4'd0,
		PH_ADDR_ACK_RX    = 4'd2,
		PH_ADDR_ACK_CHECK = 4'd4,
		PH_RESTART        = 4'd5,
		PH_DATA_ACK_TX    = 4'd6,
		PH_PREP_STOP      = 4'd8,
		PH_DATA_ACK_RX    = 4'd10,
		PH_DATA_ACK_CHECK = 4'd12,
		PH_STOP           = 4'd14
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [1:0] count_q, count_d;
	logic       is_write_q, is_write_d;
	logic       rd_sent_q, rd_sent_d;
	logic [7:0] reg_q, reg_d;
	logic [7:0] data_q, data_d;
	logic [7:0] rx_q, rx_d;
	logic [7:0] dev_addr_q;

	always_comb begin
		phase_d    = phase_q;
		count_d    = count_q;
		is_write_d = is_write_q;
		rd_sent_d  = rd_sent_q;
		reg_d      = reg_q;
		data_d     = data_q;
		rx_d       = rx_q;
		result     = '{BYTE_RELEASED, CNT_NONE, 1'b0, ACT_NONE, 1'b0, rx_q};
		case (cmd.operation)
			OP_START_WRITE, OP_START_READ: begin
				is_write_d = (cmd.operation == OP_START_WRITE);
				reg_d      = cmd.reg_address;
				if (cmd.operation == OP_START_WRITE) begin
					data_d = cmd.write_data;
				end
				rd_sent_d = 1'b0;
				count_d   = 2'd0;
				phase_d   = PH_ADDR_ACK_RX;
				result    = '{dev_addr_q, CNT_BYTE, 1'b1, ACT_START, 1'b0, rx_q};
			end
			OP_SHIFT_DONE: begin
				case (phase_q)
					PH_ADDR_ACK_RX: begin
						phase_d = PH_ADDR_ACK_CHECK;
						result  = '{BYTE_RELEASED, CNT_ACK, 1'b0, ACT_NONE, 1'b0, rx_q};
					end
					PH_ADDR_ACK_CHECK: begin
						if (cmd.shifted_in[0]) begin
							phase_d = PH_STOP;
							result  = '{BYTE_ZERO, CNT_ACK, 1'b1, ACT_NONE, 1'b0, rx_q};
						end else if (rd_sent_q) begin
							phase_d = PH_DATA_ACK_TX;
							result  = '{BYTE_RELEASED, CNT_BYTE, 1'b0, ACT_NONE, 1'b0, rx_q};
						end else begin
							count_d = count_q + 2'd1;
							phase_d = PH_DATA_ACK_RX;
							result  = '{reg_q, CNT_BYTE, 1'b1, ACT_NONE, 1'b0, rx_q};
						end
					end
					PH_RESTART: begin
						rd_sent_d = 1'b1;
						phase_d   = PH_ADDR_ACK_RX;
						result    = '{dev_addr_q + READ_BIT, CNT_BYTE, 1'b1, ACT_START,
							1'b0, rx_q};
					end
					PH_DATA_ACK_TX: begin
						rx_d = cmd.shifted_in;
						if (count_q <= TxCnt) begin
							count_d = count_q + 2'd1;
							phase_d = PH_ADDR_ACK_CHECK;
							result  = '{BYTE_ZERO, CNT_ACK, 1'b1, ACT_NONE, 1'b0,
								cmd.shifted_in};
						end else begin
							phase_d = PH_PREP_STOP;
							result  = '{BYTE_RELEASED, CNT_ACK, 1'b1, ACT_NONE, 1'b0,
								cmd.shifted_in};
						end
					end
					PH_PREP_STOP: begin
						phase_d = PH_STOP;
						result  = '{BYTE_ZERO, CNT_ACK, 1'b1, ACT_NONE, 1'b0, rx_q};
					end
					PH_DATA_ACK_RX: begin
						phase_d = PH_DATA_ACK_CHECK;
						result  = '{BYTE_RELEASED, CNT_ACK, 1'b0, ACT_NONE, 1'b0, rx_q};
					end
					PH_DATA_ACK_CHECK: begin
						if (is_write_q) begin
							count_d = count_q + 2'd1;
							if (count_q == LastCnt) begin
								phase_d = PH_STOP;
								result  = '{BYTE_ZERO, CNT_ACK, 1'b1, ACT_NONE, 1'b0, rx_q};
							end else begin
								phase_d = PH_DATA_ACK_RX;
								result  = '{data_q, CNT_BYTE, 1'b1, ACT_NONE, 1'b0, rx_q};
							end
						end else begin
							phase_d = PH_RESTART;
							result  = '{BYTE_RELEASED, CNT_ACK, 1'b1, ACT_NONE, 1'b0, rx_q};
						end
					end
					PH_STOP: begin
						phase_d   = PH_IDLE;
						rd_sent_d = 1'b0;
						result    = '{BYTE_RELEASED, CNT_NONE, 1'b0, ACT_STOP, 1'b1, rx_q};
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
			default: begin
				// unused code leaves everything as it is
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			count_q    <= 2'd0;
			is_write_q <= 1'b0;
			rd_sent_q  <= 1'b0;
			reg_q      <= 8'd0;
			data_q     <= 8'd0;
			rx_q       <= 8'd0;
			dev_addr_q <= 8'd0;
		end else begin
			if (accept) begin
				phase_q    <= phase_d;
				count_q    <= count_d;
				is_write_q <= is_write_d;
				rd_sent_q  <= rd_sent_d;
				reg_q      <= reg_d;
				data_q     <= data_d;
				rx_q       <= rx_d;
			end
			if (cfg_we) begin
				dev_addr_q <= cfg_data;
			end
		end
	end

endmodule

### rtl/core/i2c_master_register_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_register_sequencer
// Byte-level I2C master sequencer for single-register write and read.
//
//   channel  dir  payload
//   cmd      in   operation, reg_address, write_data, shifted_in
//   rsp      out  shift_value, bit_count, sda_drive, line_action, done_res,
//                 read_data
//   cfg      in   data (device address byte)
//
// one item a cycle while rsp is not stalled; each item's result is registered and shown in the cycle after acceptance
// the result register decouples the sides: cmd is ready while it is empty
// or being emptied, so a stalled rsp holds at most one item
// reset clears the transaction state, the device address and the result valid
// cfg is always ready
// ----------------------------------------------------------------------------
module i2c_master_register_sequencer import i2cmrs_pkg::*; #(
	parameter int WRITE_BYTES = 2
) (
	input  logic clk,
	input  logic arst_n,
	i2cmrs_cmd_if.sink   cmd,
	i2cmrs_rsp_if.source rsp,
	i2cmrs_cfg_if.sink   cfg
);

	cmd_t    cmd_item;
	result_t result;
	result_t rsp_q;
	logic    rsp_valid_q;
	logic    accept;

	assign cmd_item  = '{cmd.operation, cmd.reg_address, cmd.write_data, cmd.shifted_in};
	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign accept    = cmd.valid && cmd.ready;
	assign cfg.ready = 1'b1;

	i2cmrs_seq #(
		.WRITE_BYTES(WRITE_BYTES)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.cmd     (cmd_item),
		.cfg_we  (cfg.valid),
		.cfg_data(cfg.data),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= result;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.shift_value = rsp_q.shift_value;
	assign rsp.bit_count   = rsp_q.bit_count;
	assign rsp.sda_drive   = rsp_q.sda_drive;
	assign rsp.line_action = rsp_q.line_action;
	assign rsp.done_res    = rsp_q.done_res;
	assign rsp.read_data   = rsp_q.read_data;

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp.valid)
		else $error("accepted item produced no result");

	a_done_with_stop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.done_res |-> rsp.line_action == ACT_STOP && !rsp.sda_drive)
		else $error("done without stop");

	a_released_line: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.sda_drive |-> rsp.shift_value == BYTE_RELEASED)
		else $error("released sda with a loaded byte");

	a_bit_count_legal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.bit_count == CNT_NONE || rsp.bit_count == CNT_ACK
			|| rsp.bit_count == CNT_BYTE)
		else $error("bad bit count");

endmodule

### test/i2c_master_register_sequencer_test.sv
// ----------------------------------------------------------------------------
// i2c_master_register_sequencer_test
// Drives register write and read transfers, address nacks, aborts and stray
// events through the sequencer under several device addresses, with random
// gaps and response stalls. A transfer tracker predicts every result and
// checks it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module i2c_master_register_sequencer_test;
	import i2cmrs_pkg::*;

	localparam int WRITE_BYTES = 2;

	typedef enum logic [3:0] {
		ST_IDLE           = 4'd0,
		ST_ADDR_ACK_WAIT  = 4'd2,
		ST_ADDR_ACK_CHECK = 4'd4,
		ST_RESTART        = 4'd5,
		ST_READ_BYTE      = 4'd6,
		ST_PREP_STOP      = 4'd8,
		ST_DATA_ACK_WAIT  = 4'd10,
		ST_DATA_ACK_CHECK = 4'd12,
		ST_STOP           = 4'd14
	} seq_state_t;

	class transfer_tracker;
		seq_state_t state;
		logic [1:0] byte_count;
		logic       writing;
		logic       read_addr_sent;
		logic [7:0] dev_addr;
		logic [7:0] reg_addr;
		logic [7:0] data_byte;
		logic [7:0] rx_byte;
		result_t    expected[$];
		int         failures;

		function new();
			state = ST_IDLE;
			byte_count = '0;
			writing = 1'b0;
			read_addr_sent = 1'b0;
			dev_addr = '0;
			reg_addr = '0;
			data_byte = '0;
			rx_byte = '0;
			failures = 0;
		endfunction

		function void set_address(logic [7:0] value);
			dev_addr = value;
		endfunction

		function bit busy();
			return state != ST_IDLE;
		endfunction

		function int pending();
			return expected.size();
		endfunction

		function result_t outcome(logic [7:0] sv, logic [3:0] cnt, logic sda,
			logic [1:0] act, logic dn);
			result_t r;
			r.shift_value = sv;
			r.bit_count = cnt;
			r.sda_drive = sda;
			r.line_action = act;
			r.done_res = dn;
			r.read_data = '0;
			return r;
		endfunction

		function void take_command(cmd_t c);
			result_t r;
			case (c.operation)
				OP_START_WRITE, OP_START_READ: begin
					writing = (c.operation == OP_START_WRITE);
					reg_addr = c.reg_address;
					if (writing)
						data_byte = c.write_data;
					read_addr_sent = 1'b0;
					byte_count = '0;
					state = ST_ADDR_ACK_WAIT;
					r = outcome(dev_addr, CNT_BYTE, 1'b1, ACT_START, 1'b0);
				end
				OP_SHIFT_DONE: begin
					case (state)
						ST_ADDR_ACK_WAIT: begin
							state = ST_ADDR_ACK_CHECK;
							r = outcome(BYTE_RELEASED, CNT_ACK, 1'b0, ACT_NONE, 1'b0);
						end
						ST_ADDR_ACK_CHECK: begin
							if (c.shifted_in[0]) begin
								state = ST_STOP;
								r = outcome(BYTE_ZERO, CNT_ACK, 1'b1, ACT_NONE, 1'b0);
							end else if (read_addr_sent) begin
								state = ST_READ_BYTE;
								r = outcome(BYTE_RELEASED, CNT_BYTE, 1'b0, ACT_NONE, 1'b0);
							end else begin
								byte_count++;
								state = ST_DATA_ACK_WAIT;
								r = outcome(reg_addr, CNT_BYTE, 1'b1, ACT_NONE, 1'b0);
							end
						end
						ST_RESTART: begin
							read_addr_sent = 1'b1;
							state = ST_ADDR_ACK_WAIT;
							r = outcome(dev_addr + READ_BIT, CNT_BYTE, 1'b1, ACT_START, 1'b0);
						end
						ST_READ_BYTE: begin
							rx_byte = c.shifted_in;
							if (int'(byte_count) <= WRITE_BYTES - 2) begin
								byte_count++;
								state = ST_ADDR_ACK_CHECK;
								r = outcome(BYTE_ZERO, CNT_ACK, 1'b1, ACT_NONE, 1'b0);
							end else begin
								state = ST_PREP_STOP;
								r = outcome(BYTE_RELEASED, CNT_ACK, 1'b1, ACT_NONE, 1'b0);
							end
						end
						ST_PREP_STOP: begin
							state = ST_STOP;
							r = outcome(BYTE_ZERO, CNT_ACK, 1'b1, ACT_NONE, 1'b0);
						end
						ST_DATA_ACK_WAIT: begin
							state = ST_DATA_ACK_CHECK;
							r = outcome(BYTE_RELEASED, CNT_ACK, 1'b0, ACT_NONE, 1'b0);
						end
						ST_DATA_ACK_CHECK: begin
							if (!writing) begin
								state = ST_RESTART;
								r = outcome(BYTE_RELEASED, CNT_ACK, 1'b1, ACT_NONE, 1'b0);
							end else if (int'(byte_count) == WRITE_BYTES) begin
								byte_count++;
								state = ST_STOP;
								r = outcome(BYTE_ZERO, CNT_ACK, 1'b1, ACT_NONE, 1'b0);
							end else begin
								byte_count++;
								state = ST_DATA_ACK_WAIT;
								r = outcome(data_byte, CNT_BYTE, 1'b1, ACT_NONE, 1'b0);
							end
						end
						ST_STOP: begin
							state = ST_IDLE;
							read_addr_sent = 1'b0;
							r = outcome(BYTE_RELEASED, CNT_NONE, 1'b0, ACT_STOP, 1'b1);
						end
						default: begin
							state = ST_IDLE;
							r = outcome(BYTE_RELEASED, CNT_NONE, 1'b0, ACT_NONE, 1'b0);
						end
					endcase
				end
				default: r = outcome(BYTE_RELEASED, CNT_NONE, 1'b0, ACT_NONE, 1'b0);
			endcase
			r.read_data = rx_byte;
			expected.push_back(r);
		endfunction

		function void compare(string field, int want, int got);
			if (want != got) begin
				$display("%0t: %s expected 0x%0h got 0x%0h", $time, field, want, got);
				failures++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected.size() == 0) begin
				$display("%0t: unexpected result 0x%0h", $time, got);
				failures++;
				return;
			end
			want = expected.pop_front();
			compare("shift_value", want.shift_value, got.shift_value);
			compare("bit_count", want.bit_count, got.bit_count);
			compare("sda_drive", want.sda_drive, got.sda_drive);
			compare("line_action", want.line_action, got.line_action);
			compare("done_res", want.done_res, got.done_res);
			compare("read_data", want.read_data, got.read_data);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	i2cmrs_cmd_if cmd_ch ();
	i2cmrs_rsp_if rsp_ch ();
	i2cmrs_cfg_if cfg_ch ();

	i2c_master_register_sequencer #(
		.WRITE_BYTES(WRITE_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	transfer_tracker tracker;
	int items_sent;
	int send_calm;
	int stall_left = 0;
	int stall_calm = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// mostly ack on bit 0, the rest random
	function automatic logic [7:0] line_byte();
		logic [7:0] b;
		b = 8'($urandom);
		if ($urandom_range(0, 9) != 0)
			b[0] = 1'b0;
		return b;
	endfunction

	function automatic logic [1:0] start_op();
		return ($urandom_range(0, 1) != 0) ? OP_START_READ : OP_START_WRITE;
	endfunction

	// response side stalls
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_calm > 0) begin
				stall_calm--;
				rsp_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				stall_left = pick_gap();
				if ($urandom_range(0, 49) == 0)
					stall_calm = $urandom_range(30, 150);
			end
		end else begin
			rsp_ch.ready <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready)
				tracker.check_result({rsp_ch.shift_value, rsp_ch.bit_count, rsp_ch.sda_drive,
					rsp_ch.line_action, rsp_ch.done_res, rsp_ch.read_data});
			if (cmd_ch.valid && cmd_ch.ready)
				tracker.take_command({cmd_ch.operation, cmd_ch.reg_address,
					cmd_ch.write_data, cmd_ch.shifted_in});
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_cmd(logic [1:0] op, logic [7:0] reg_a, logic [7:0] data,
		logic [7:0] sh);
		int gap;
		if (send_calm > 0) begin
			send_calm--;
			gap = 0;
		end else begin
			gap = pick_gap();
			if ($urandom_range(0, 49) == 0)
				send_calm = $urandom_range(30, 150);
		end
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.operation <= op;
		cmd_ch.reg_address <= reg_a;
		cmd_ch.write_data <= data;
		cmd_ch.shifted_in <= sh;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic finish_transfer(logic [7:0] sh);
		while (tracker.busy())
			send_cmd(OP_SHIFT_DONE, 8'h00, 8'h00, sh);
	endtask

	task automatic run_transfer();
		int steps;
		int r;
		steps = 0;
		send_cmd(start_op(), 8'($urandom), 8'($urandom), 8'($urandom));
		while (tracker.busy() && steps < 40) begin
			r = $urandom_range(0, 99);
			if (r < 3)
				send_cmd(OP_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom));
			else if (r < 6)
				send_cmd(start_op(), 8'($urandom), 8'($urandom), 8'($urandom));
			else
				send_cmd(OP_SHIFT_DONE, 8'($urandom), 8'($urandom), line_byte());
			steps++;
		end
	endtask

	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (tracker.pending() > 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_address(logic [7:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		tracker.set_address(value);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic random_phase(int target);
		while (items_sent < target) begin
			if ($urandom_range(0, 9) == 0)
				send_cmd(($urandom_range(0, 1) != 0) ? OP_UNUSED : OP_SHIFT_DONE,
					8'($urandom), 8'($urandom), 8'($urandom));
			else
				run_transfer();
		end
	endtask

	initial begin
		logic [7:0] addr_list[5];
		tracker = new();
		items_sent = 0;
		send_calm = 0;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.operation = OP_SHIFT_DONE;
		cmd_ch.reg_address = '0;
		cmd_ch.write_data = '0;
		cmd_ch.shifted_in = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// stray events while idle, then full transfers at the top address
		send_cmd(OP_SHIFT_DONE, 8'h00, 8'h00, 8'hFF);
		send_cmd(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF);
		drain();
		write_address(8'd254);
		send_cmd(OP_START_WRITE, 8'hFF, 8'h00, 8'h00);
		finish_transfer(8'h00);
		send_cmd(OP_START_READ, 8'h00, 8'hFF, 8'hFF);
		finish_transfer(8'hFE);
		// abort by a new start, then address nack
		send_cmd(OP_START_READ, 8'h5A, 8'hA5, 8'h00);
		send_cmd(OP_START_WRITE, 8'hA5, 8'h5A, 8'h00);
		send_cmd(OP_SHIFT_DONE, 8'h00, 8'h00, 8'h00);
		send_cmd(OP_SHIFT_DONE, 8'h00, 8'h00, 8'h01);
		finish_transfer(8'h00);

		addr_list[0] = 8'd254;
		addr_list[1] = 8'd0;
		addr_list[2] = 8'd1;
		addr_list[3] = 8'($urandom_range(0, 254));
		addr_list[4] = 8'($urandom_range(0, 254));
		foreach (addr_list[i]) begin
			drain();
			write_address(addr_list[i]);
			random_phase(25 + 145 * (i + 1));
		end
		drain();
		repeat (4) @(negedge clk);

		if (tracker.failures == 0 && tracker.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### i2c_master_register_sequencer.f
rtl/core/i2cmrs_pkg.sv
rtl/core/i2cmrs_if.sv
rtl/core/i2cmrs_seq.sv
rtl/core/i2c_master_register_sequencer.sv
test/i2c_master_register_sequencer_test.sv
